// File: hdl/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared types and default sizes for the stable item sorter.
// ----------------------------------------------------------------------------
package ssi_pkg;

   localparam int MAX_ITEMS_DEFAULT  = 64;
   localparam int ITEM_WIDTH_DEFAULT = 32;
   localparam int VALUE_WIDTH        = 32;

   // command broadcast from the controller to every cell of a chain
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_FILL  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

endpackage

// File: hdl/stable_sort_items.sv
// ----------------------------------------------------------------------------
// stable_sort_items
// Stable batch sorter. Items are taken one per cycle while a batch fills;
// each beat is inserted at once into two chains of MAX_ITEMS cells, one kept
// in ascending and one in descending order, so a batch of n items is in
// order the cycle after its last beat. The order bit seen with the last beat
// picks the chain, which then shifts out one result per cycle toward cell 0
// while rsp_stall is low, and the input stalls during the burst. Equal items
// leave in arrival order. Beats beyond MAX_ITEMS are dropped and every
// result of that batch carries the overflow flag.
// ----------------------------------------------------------------------------
module stable_sort_items #(
   parameter int MAX_ITEMS  = ssi_pkg::MAX_ITEMS_DEFAULT,
   parameter int ITEM_WIDTH = ssi_pkg::ITEM_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ssi_pkg::VALUE_WIDTH-1:0]  req_item_value,
   input  logic                             req_last_item,
   input  logic                             csr_wr_en,
   input  logic                             csr_wr_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ssi_pkg::VALUE_WIDTH-1:0]  rsp_sorted_value,
   output logic                             rsp_last_result,
   output logic                             rsp_overflow_seen
);
   import ssi_pkg::*;

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  dropped_ff, dropped_in;
   logic                  ascending_ff;
   logic                  up_sel_ff, up_sel_in;

   logic                  req_fire;
   logic                  rsp_fire;
   logic                  full;
   logic [ITEM_WIDTH-1:0] item_value;
   logic [ITEM_WIDTH-1:0] head_value;
   cell_cmd_type          cmd;

   logic                  asc_valid [MAX_ITEMS];
   logic [ITEM_WIDTH-1:0] asc_value [MAX_ITEMS];
   logic                  asc_ins   [MAX_ITEMS];
   logic                  dsc_valid [MAX_ITEMS];
   logic [ITEM_WIDTH-1:0] dsc_value [MAX_ITEMS];
   logic                  dsc_ins   [MAX_ITEMS];

   assign req_stall = (state_ff != ST_FILL);
   assign rsp_valid = (state_ff == ST_DRAIN);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign full      = (count_ff == CNT_W'(MAX_ITEMS));

   assign cmd.insert = req_fire && !full;
   assign cmd.shift  = rsp_fire;

   // item width adaptation between the 32-bit ports and the cell width
   if (ITEM_WIDTH < VALUE_WIDTH) begin : g_narrow
      assign item_value       = req_item_value[ITEM_WIDTH-1:0];
      assign rsp_sorted_value = {{(VALUE_WIDTH-ITEM_WIDTH){1'b0}}, head_value};
   end else if (ITEM_WIDTH == VALUE_WIDTH) begin : g_equal
      assign item_value       = req_item_value;
      assign rsp_sorted_value = head_value;
   end else begin : g_wide
      assign item_value       = {{(ITEM_WIDTH-VALUE_WIDTH){1'b0}}, req_item_value};
      assign rsp_sorted_value = head_value[VALUE_WIDTH-1:0];
   end

   assign head_value        = up_sel_ff ? asc_value[0] : dsc_value[0];
   assign rsp_last_result   = (count_ff == CNT_W'(1));
   assign rsp_overflow_seen = dropped_ff;

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic                  l_ins_a, l_valid_a, l_ins_d, l_valid_d;
      logic [ITEM_WIDTH-1:0] l_value_a, l_value_d;
      logic                  r_valid_a, r_valid_d;
      logic [ITEM_WIDTH-1:0] r_value_a, r_value_d;

      if (i == 0) begin : g_head
         assign l_ins_a   = 1'b0;
         assign l_valid_a = 1'b0;
         assign l_value_a = '0;
         assign l_ins_d   = 1'b0;
         assign l_valid_d = 1'b0;
         assign l_value_d = '0;
      end else begin : g_mid
         assign l_ins_a   = asc_ins[i-1];
         assign l_valid_a = asc_valid[i-1];
         assign l_value_a = asc_value[i-1];
         assign l_ins_d   = dsc_ins[i-1];
         assign l_valid_d = dsc_valid[i-1];
         assign l_value_d = dsc_value[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_tail
         assign r_valid_a = 1'b0;
         assign r_value_a = '0;
         assign r_valid_d = 1'b0;
         assign r_value_d = '0;
      end else begin : g_body
         assign r_valid_a = asc_valid[i+1];
         assign r_value_a = asc_value[i+1];
         assign r_valid_d = dsc_valid[i+1];
         assign r_value_d = dsc_value[i+1];
      end

      ssi_cell #(
         .ITEM_WIDTH (ITEM_WIDTH),
         .ASCENDING  (1'b1)
      ) u_asc (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .new_value   (item_value),
         .left_ins    (l_ins_a),
         .left_valid  (l_valid_a),
         .left_value  (l_value_a),
         .right_valid (r_valid_a),
         .right_value (r_value_a),
         .valid       (asc_valid[i]),
         .value       (asc_value[i]),
         .ins         (asc_ins[i])
      );

      ssi_cell #(
         .ITEM_WIDTH (ITEM_WIDTH),
         .ASCENDING  (1'b0)
      ) u_dsc (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .new_value   (item_value),
         .left_ins    (l_ins_d),
         .left_valid  (l_valid_d),
         .left_value  (l_value_d),
         .right_valid (r_valid_d),
         .right_value (r_value_d),
         .valid       (dsc_valid[i]),
         .value       (dsc_value[i]),
         .ins         (dsc_ins[i])
      );
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      up_sel_in  = up_sel_ff;
      case (state_ff)
         ST_FILL: begin
            if (req_fire) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_last_item) begin
                  state_in  = ST_DRAIN;
                  up_sel_in = ascending_ff;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_fire) begin
               count_in = count_ff - CNT_W'(1);
               if (rsp_last_result) begin
                  state_in   = ST_FILL;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         ascending_ff <= 1'b1;
         up_sel_ff    <= 1'b1;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         up_sel_ff  <= up_sel_in;
         if (csr_wr_en) begin
            ascending_ff <= csr_wr_data;
         end
      end
   end

endmodule

// File: hdl/ssi_cell.sv
// ----------------------------------------------------------------------------
// ssi_cell
// One slot of a systolic insertion chain: holds one item and either makes
// room for a new item, keeps its own, or takes its right neighbor on drain.
// ----------------------------------------------------------------------------
module ssi_cell #(
   parameter int ITEM_WIDTH = ssi_pkg::ITEM_WIDTH_DEFAULT,
   parameter bit ASCENDING  = 1'b1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ssi_pkg::cell_cmd_type   cmd,
   input  logic [ITEM_WIDTH-1:0]   new_value,
   input  logic                    left_ins,
   input  logic                    left_valid,
   input  logic [ITEM_WIDTH-1:0]   left_value,
   input  logic                    right_valid,
   input  logic [ITEM_WIDTH-1:0]   right_value,
   output logic                    valid,
   output logic [ITEM_WIDTH-1:0]   value,
   output logic                    ins
);
   import ssi_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [ITEM_WIDTH-1:0] value_ff;
   logic [ITEM_WIDTH-1:0] value_in;
   logic                  new_first;

   // strict compare: an equal newcomer stays behind, which keeps ties stable
   assign new_first = ASCENDING ? (new_value < value_ff) : (value_ff < new_value);
   assign ins       = !valid_ff || new_first;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (cmd.insert && ins) begin
         if (left_ins) begin
            valid_in = left_valid;
            value_in = left_value;
         end else begin
            valid_in = 1'b1;
            value_in = new_value;
         end
      end else if (cmd.shift) begin
         valid_in = right_valid;
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;

endmodule
